[sv/ftok_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftok_pkg
// Shared types and constants of the formula tokenizer.
// ----------------------------------------------------------------------------
package ftok_pkg;

    localparam int MAX_LEN_DEF = 1024;
    localparam int NUM_SLOTS   = 6;

    typedef enum logic [4:0] {
        K_END = 5'd0, K_NUMBER = 5'd1, K_STRING = 5'd2, K_CELLREF = 5'd3,
        K_BOOL = 5'd4, K_IDENT = 5'd5, K_PLUS = 5'd6, K_MINUS = 5'd7,
        K_MUL = 5'd8, K_DIV = 5'd9, K_POW = 5'd10, K_AMP = 5'd11,
        K_LPAREN = 5'd12, K_RPAREN = 5'd13, K_COMMA = 5'd14, K_SEMI = 5'd15,
        K_COLON = 5'd16, K_EQ = 5'd17, K_NE = 5'd18, K_LE = 5'd19,
        K_LT = 5'd20, K_GE = 5'd21, K_GT = 5'd22, K_ERROR = 5'd23
    } kind_t;

    typedef enum logic [3:0] {
        M_START, M_IDLE, M_INT, M_FRAC, M_EXPMARK, M_EXPDIG, M_DOT, M_STR,
        M_STRQ, M_DOLLAR, M_LET, M_LETD, M_ROW, M_OP
    } mode_t;

    // word match codes for TRUE / FALSE recognition
    localparam logic [3:0] WM_NONE  = 4'd0;
    localparam logic [3:0] WM_TRUE  = 4'd4;
    localparam logic [3:0] WM_FALSE = 4'd9;
    localparam logic [3:0] WM_FAIL  = 4'd15;

    localparam logic [14:0] COL_SAT = 15'd16384;
    localparam logic [20:0] ROW_SAT = 21'd1048576;

    // one token as it leaves on the result channel, lowest field last
    typedef struct packed {
        logic               last;
        logic               truth;
        logic               rabs;
        logic               cabs;
        logic signed [20:0] row;
        logic [13:0]        col;
        logic [10:0]        len;
        logic [9:0]         start;
        kind_t              kind;
    } tok_t;

    typedef struct packed {
        logic [14:0] col;
        logic [3:0]  wm;
    } letter_t;

endpackage
`default_nettype wire

[sv/ftok_lexer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftok_lexer
// Lexer state and the single-pass next-state logic; yields up to six
// token slots per character.
// ----------------------------------------------------------------------------
module ftok_lexer #(
    parameter int MAX_LEN = ftok_pkg::MAX_LEN_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               advance,
    input  wire logic [7:0]                         character,
    input  wire logic                               final_char,
    output ftok_pkg::tok_t [ftok_pkg::NUM_SLOTS-1:0] slots,
    output logic [ftok_pkg::NUM_SLOTS-1:0]          slot_valid
);
    import ftok_pkg::*;

    localparam int PW = $clog2(MAX_LEN + 1);

    mode_t          mode_reg, mode_next;
    logic [PW-1:0]  pos_reg, pos_next;
    logic [PW-1:0]  start_reg, start_next;
    logic [14:0]    col_reg, col_next;
    logic [20:0]    row_reg, row_next;
    logic [3:0]     wm_reg, wm_next;
    logic [1:0]     flag_reg, flag_next;
    logic [7:0]     held_reg, held_next;

    logic           go_start;
    letter_t        lt_cur, lt_new;
    logic [31:0]    p32, pm1, ef, efm1;

    function automatic logic is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic letter_t add_letter(logic [14:0] col, logic [3:0] wm,
                                           logic [7:0] c);
        logic [7:0]  u;
        logic [19:0] acc;
        letter_t     r;
        u   = (c >= "a") ? c - 8'd32 : c;
        acc = 20'(col) * 20'd26 + 20'(u - 8'd64);
        r.col = (acc > 20'(COL_SAT)) ? COL_SAT : acc[14:0];
        unique case (wm)
            4'd0:    r.wm = (u == "T") ? 4'd1 : (u == "F") ? 4'd5 : WM_FAIL;
            4'd1:    r.wm = (u == "R") ? 4'd2 : WM_FAIL;
            4'd2:    r.wm = (u == "U") ? 4'd3 : WM_FAIL;
            4'd3:    r.wm = (u == "E") ? 4'd4 : WM_FAIL;
            4'd5:    r.wm = (u == "A") ? 4'd6 : WM_FAIL;
            4'd6:    r.wm = (u == "L") ? 4'd7 : WM_FAIL;
            4'd7:    r.wm = (u == "S") ? 4'd8 : WM_FAIL;
            4'd8:    r.wm = (u == "E") ? 4'd9 : WM_FAIL;
            default: r.wm = WM_FAIL;
        endcase
        return r;
    endfunction

    function automatic logic [20:0] add_digit(logic [20:0] row, logic [7:0] c);
        logic [24:0] acc;
        acc = 25'(row) * 25'd10 + 25'(c - "0");
        return (acc > 25'(ROW_SAT)) ? ROW_SAT : acc[20:0];
    endfunction

    function automatic tok_t mk(kind_t kind, logic [31:0] st, logic [31:0] en,
                                logic [13:0] col, logic [20:0] row,
                                logic [1:0] flags, logic truth, logic last);
        logic [31:0] l;
        logic [31:0] s;
        tok_t        t;
        l = (en >= st) ? en - st : 32'd0;
        if (l > 32'(MAX_LEN)) l = 32'(MAX_LEN);
        s = (st > 32'(MAX_LEN - 1)) ? 32'(MAX_LEN - 1) : st;
        t.kind  = kind;
        t.start = s[9:0];
        t.len   = l[10:0];
        t.col   = col;
        t.row   = row;
        t.cabs  = flags[0];
        t.rabs  = flags[1];
        t.truth = truth;
        t.last  = last;
        return t;
    endfunction

    function automatic tok_t simple(kind_t kind, logic [31:0] st, logic [31:0] en);
        return mk(kind, st, en, 14'd0, 21'd0, 2'b00, 1'b0, 1'b0);
    endfunction

    function automatic tok_t word(logic [3:0] wm, logic [31:0] st, logic [31:0] en);
        tok_t t;
        if (wm == WM_TRUE) begin
            t = mk(K_BOOL, st, en, 14'd0, 21'd0, 2'b00, 1'b1, 1'b0);
        end else if (wm == WM_FALSE) begin
            t = mk(K_BOOL, st, en, 14'd0, 21'd0, 2'b00, 1'b0, 1'b0);
        end else begin
            t = simple(K_IDENT, st, en);
        end
        return t;
    endfunction

    function automatic tok_t cellref(logic [31:0] st, logic [31:0] en,
                                     logic [14:0] col, logic [20:0] row,
                                     logic [1:0] flags);
        logic [14:0] c;
        c = (col != 15'd0) ? col - 15'd1 : 15'd0;
        return mk(K_CELLREF, st, en, c[13:0], row - 21'd1, flags, 1'b0, 1'b0);
    endfunction

    function automatic kind_t op_kind(logic [7:0] c);
        kind_t k;
        unique case (c)
            "+":     k = K_PLUS;
            "-":     k = K_MINUS;
            "*":     k = K_MUL;
            "/":     k = K_DIV;
            "^":     k = K_POW;
            "&":     k = K_AMP;
            "(":     k = K_LPAREN;
            ")":     k = K_RPAREN;
            ",":     k = K_COMMA;
            ";":     k = K_SEMI;
            ":":     k = K_COLON;
            "=":     k = K_EQ;
            default: k = K_ERROR;
        endcase
        return k;
    endfunction

    assign lt_cur = add_letter(col_reg, wm_reg, character);
    assign lt_new = add_letter(15'd0, WM_NONE, character);
    assign p32    = 32'(pos_reg);
    assign pm1    = (pos_reg == '0) ? 32'd0 : p32 - 32'd1;
    assign ef     = 32'(pos_next);
    assign efm1   = (pos_next == '0) ? 32'd0 : ef - 32'd1;
    assign pos_next = (pos_reg < PW'(MAX_LEN)) ? pos_reg + PW'(1) : PW'(MAX_LEN);

    always_comb begin
        mode_next  = mode_reg;
        start_next = start_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        wm_next    = wm_reg;
        flag_next  = flag_reg;
        held_next  = held_reg;
        slots      = '0;
        slot_valid = '0;
        go_start   = 1'b0;

        // close or extend the token in progress
        unique case (mode_reg)
            M_START: begin
                mode_next = M_IDLE;
                go_start  = (character != "=");
            end
            M_IDLE: go_start = 1'b1;
            M_INT, M_FRAC: begin
                if (is_digit(character)) begin
                end else if (character == "." && mode_reg == M_INT) begin
                    mode_next = M_FRAC;
                end else if (character == "e" || character == "E") begin
                    mode_next = M_EXPMARK;
                end else begin
                    slots[0] = simple(K_NUMBER, 32'(start_reg), p32);
                    slot_valid[0] = 1'b1;
                    go_start = 1'b1;
                end
            end
            M_EXPMARK: begin
                if (character == "+" || character == "-" || is_digit(character)) begin
                    mode_next = M_EXPDIG;
                end else begin
                    slots[0] = simple(K_NUMBER, 32'(start_reg), p32);
                    slot_valid[0] = 1'b1;
                    go_start = 1'b1;
                end
            end
            M_EXPDIG: begin
                if (!is_digit(character)) begin
                    slots[0] = simple(K_NUMBER, 32'(start_reg), p32);
                    slot_valid[0] = 1'b1;
                    go_start = 1'b1;
                end
            end
            M_DOT: begin
                if (is_digit(character)) begin
                    mode_next = M_FRAC;
                end else begin
                    slots[0] = simple(K_ERROR, 32'(start_reg), 32'(start_reg) + 32'd1);
                    slot_valid[0] = 1'b1;
                    go_start = 1'b1;
                end
            end
            M_STR: begin
                if (character == "\"") mode_next = M_STRQ;
            end
            M_STRQ: begin
                if (character == "\"") begin
                    mode_next = M_STR;
                end else begin
                    slots[0] = simple(K_STRING, 32'(start_reg), p32);
                    slot_valid[0] = 1'b1;
                    go_start = 1'b1;
                end
            end
            M_DOLLAR: begin
                if (is_alpha(character)) begin
                    mode_next = M_LET;
                    col_next  = lt_cur.col;
                    wm_next   = lt_cur.wm;
                end else begin
                    slots[0] = simple(K_ERROR, 32'(start_reg), 32'(start_reg) + 32'd1);
                    slot_valid[0] = 1'b1;
                    go_start = 1'b1;
                end
            end
            M_LET: begin
                if (is_alpha(character)) begin
                    col_next = lt_cur.col;
                    wm_next  = lt_cur.wm;
                end else if (character == "$") begin
                    mode_next = M_LETD;
                end else if (is_digit(character)) begin
                    mode_next = M_ROW;
                    row_next  = add_digit(row_reg, character);
                end else begin
                    slots[0] = word(wm_reg, 32'(start_reg), p32);
                    slot_valid[0] = 1'b1;
                    go_start = 1'b1;
                end
            end
            M_LETD: begin
                if (is_digit(character)) begin
                    flag_next = flag_reg | 2'b10;
                    mode_next = M_ROW;
                    row_next  = add_digit(row_reg, character);
                end else begin
                    // hand the dangling dollar to a fresh token
                    slots[0] = word(wm_reg, 32'(start_reg), pm1);
                    slot_valid[0] = 1'b1;
                    start_next = PW'(pm1);
                    flag_next  = 2'b01;
                    row_next   = '0;
                    if (is_alpha(character)) begin
                        mode_next = M_LET;
                        col_next  = lt_new.col;
                        wm_next   = lt_new.wm;
                    end else begin
                        col_next = '0;
                        wm_next  = WM_NONE;
                        slots[1] = simple(K_ERROR, pm1, pm1 + 32'd1);
                        slot_valid[1] = 1'b1;
                        go_start = 1'b1;
                    end
                end
            end
            M_ROW: begin
                if (is_digit(character)) begin
                    row_next = add_digit(row_reg, character);
                end else begin
                    slots[0] = cellref(32'(start_reg), p32, col_reg, row_reg, flag_reg);
                    slot_valid[0] = 1'b1;
                    go_start = 1'b1;
                end
            end
            M_OP: begin
                slot_valid[0] = 1'b1;
                mode_next = M_IDLE;
                if (held_reg == "<" && character == ">") begin
                    slots[0] = simple(K_NE, 32'(start_reg), p32 + 32'd1);
                end else if (held_reg == "<" && character == "=") begin
                    slots[0] = simple(K_LE, 32'(start_reg), p32 + 32'd1);
                end else if (held_reg == ">" && character == "=") begin
                    slots[0] = simple(K_GE, 32'(start_reg), p32 + 32'd1);
                end else begin
                    slots[0] = simple((held_reg == "<") ? K_LT : K_GT,
                                      32'(start_reg), 32'(start_reg) + 32'd1);
                    go_start = 1'b1;
                end
            end
            default: go_start = 1'b1;
        endcase

        // open a new token on this character
        if (go_start) begin
            mode_next = M_IDLE;
            if (is_space(character)) begin
            end else if (is_digit(character)) begin
                mode_next  = M_INT;
                start_next = pos_reg;
            end else if (is_alpha(character)) begin
                mode_next  = M_LET;
                start_next = pos_reg;
                flag_next  = 2'b00;
                row_next   = '0;
                col_next   = lt_new.col;
                wm_next    = lt_new.wm;
            end else begin
                unique case (character)
                    ".": begin
                        mode_next  = M_DOT;
                        start_next = pos_reg;
                    end
                    "\"": begin
                        mode_next  = M_STR;
                        start_next = pos_reg;
                    end
                    "$": begin
                        mode_next  = M_DOLLAR;
                        start_next = pos_reg;
                        flag_next  = 2'b01;
                        col_next   = '0;
                        row_next   = '0;
                        wm_next    = WM_NONE;
                    end
                    "<", ">": begin
                        mode_next  = M_OP;
                        held_next  = character;
                        start_next = pos_reg;
                    end
                    default: begin
                        slots[2] = simple(op_kind(character), p32, p32 + 32'd1);
                        slot_valid[2] = 1'b1;
                    end
                endcase
            end
        end

        // close the formula on its last character
        if (final_char) begin
            unique case (mode_next)
                M_INT, M_FRAC, M_EXPMARK, M_EXPDIG: begin
                    slots[3] = simple(K_NUMBER, 32'(start_next), ef);
                    slot_valid[3] = 1'b1;
                end
                M_DOT, M_DOLLAR: begin
                    slots[3] = simple(K_ERROR, 32'(start_next), 32'(start_next) + 32'd1);
                    slot_valid[3] = 1'b1;
                end
                M_STR, M_STRQ: begin
                    slots[3] = simple(K_STRING, 32'(start_next), ef);
                    slot_valid[3] = 1'b1;
                end
                M_LET: begin
                    slots[3] = word(wm_next, 32'(start_next), ef);
                    slot_valid[3] = 1'b1;
                end
                M_LETD: begin
                    slots[3] = word(wm_next, 32'(start_next), efm1);
                    slots[4] = simple(K_ERROR, efm1, ef);
                    slot_valid[4:3] = 2'b11;
                end
                M_ROW: begin
                    slots[3] = cellref(32'(start_next), ef, col_next, row_next, flag_next);
                    slot_valid[3] = 1'b1;
                end
                M_OP: begin
                    slots[3] = simple((held_next == "<") ? K_LT : K_GT,
                                      32'(start_next), 32'(start_next) + 32'd1);
                    slot_valid[3] = 1'b1;
                end
                default: begin
                end
            endcase
            slots[5] = mk(K_END, ef, ef, 14'd0, 21'd0, 2'b00, 1'b0, 1'b1);
            slot_valid[5] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (advance && final_char)) begin
            mode_reg  <= M_START;
            pos_reg   <= '0;
            start_reg <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
            wm_reg    <= WM_NONE;
            flag_reg  <= '0;
            held_reg  <= '0;
        end else if (advance) begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            wm_reg    <= wm_next;
            flag_reg  <= flag_next;
            held_reg  <= held_next;
        end
    end

endmodule
`default_nettype wire

[sv/formula_tokenizer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// formula_tokenizer
// Streaming spreadsheet formula lexer, one character per beat in, one
// token per beat out.
// ----------------------------------------------------------------------------
// Feed the formula one character per input beat and mark the last one with
// s_axis_tlast. For each character the lexer updates its state and files
// every token the character completes into a small result buffer, which
// drains at one token per output beat. A character that completes at most
// one token keeps the input running at one beat per cycle while
// m_axis_tready is high; one that completes several (a dangling '$', the
// last character with its END token) holds the input while the buffer
// drains. Every formula ends with an END token on m_axis_tlast, after
// which the lexer is back at start of formula.
module formula_tokenizer #(
    parameter int MAX_LEN = ftok_pkg::MAX_LEN_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // [7:0] character
    input  wire logic        s_axis_tlast,  // final_char
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [4:0] token_kind, [14:5] token_start, [25:15] token_length,
    // [39:26] column_index, [60:40] row_index, [61] column_absolute,
    // [62] row_absolute, [63] truth_value
    output logic [63:0]      m_axis_tdata,
    output logic             m_axis_tlast   // last_token
);
    import ftok_pkg::*;

    logic                   advance;
    tok_t [NUM_SLOTS-1:0]   lex_slots;
    logic [NUM_SLOTS-1:0]   lex_valid;
    tok_t [NUM_SLOTS-1:0]   slot_reg;
    logic [NUM_SLOTS-1:0]   mask_reg, mask_next;
    tok_t                   head;

    ftok_lexer #(.MAX_LEN(MAX_LEN)) u_lexer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .character  (s_axis_tdata),
        .final_char (s_axis_tlast),
        .slots      (lex_slots),
        .slot_valid (lex_valid)
    );

    // take a new character once the buffer is empty or drains its last token
    assign s_axis_tready = (mask_reg == '0) || ($onehot(mask_reg) && m_axis_tready);
    assign advance       = s_axis_tvalid && s_axis_tready;

    // present the lowest pending slot
    always_comb begin
        head = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (mask_reg[i]) head = slot_reg[i];
        end
    end

    assign m_axis_tvalid = |mask_reg;
    assign m_axis_tdata  = {head.truth, head.rabs, head.cabs, head.row, head.col,
                            head.len, head.start, head.kind};
    assign m_axis_tlast  = head.last;

    always_comb begin
        mask_next = mask_reg;
        if (advance) begin
            mask_next = lex_valid;
        end else if (m_axis_tvalid && m_axis_tready) begin
            mask_next = mask_reg & (mask_reg - NUM_SLOTS'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
        end else begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            slot_reg <= lex_slots;
        end
    end

endmodule
`default_nettype wire
